// ----- hw/rtl/fwpm_pkg.sv -----
// shared types and constants for the fuzzy wake phrase prefix matcher
package fwpm_pkg;
    localparam logic [4:0] CELL_MAX = 5'd31;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_CHARS_LOW  = 2'd0,
        REG_CHARS_HIGH = 2'd1,
        REG_LENGTH     = 2'd2,
        REG_MAX_EDITS  = 2'd3
    } t_reg_index;

    // controller to datapath commands
    typedef struct packed {
        logic start;
        logic row_init;
        logic cell_step;
        logic finish;
        logic out_load;
        logic clear;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic do_row;
        logic last_cell;
        logic is_last;
    } t_status;

    function automatic logic is_skip(input logic [7:0] c);
        return c == 8'h20 || c == 8'h2c || c == 8'h2e || c == 8'h21 ||
               c == 8'h3f || c == 8'h3b || c == 8'h3a || c == 8'h2d;
    endfunction
endpackage

// ----- hw/rtl/fwpm_if.sv -----
// valid/ready channel interfaces for items and configuration writes
interface fwpm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_last;
    modport source (output valid, text_byte, is_last, input ready);
    modport sink (input valid, text_byte, is_last, output ready);
endinterface

interface fwpm_out_if #(parameter int OFF_W = 11);
    logic             valid;
    logic             ready;
    logic             matched;
    logic [3:0]       distance;
    logic [OFF_W-1:0] remainder_start;
    logic [OFF_W-1:0] remainder_end;
    logic             text_too_long;
    modport source (output valid, matched, distance, remainder_start, remainder_end,
                    text_too_long, input ready);
    modport sink (input valid, matched, distance, remainder_start, remainder_end,
                  text_too_long, output ready);
endinterface

interface fwpm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/fwpm_ctrl.sv -----
// sequencer for one item: bookkeeping, row sweep, result hand-off
module fwpm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  fwpm_pkg::t_status i_status,
    output fwpm_pkg::t_cmd    o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_PREP, S_ROW, S_DONE, S_OUT} t_state;
    t_state r_state;
    logic   r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;

    // commands decoded from state
    always_comb begin
        o_cmd           = '0;
        o_cmd.start     = i_in_valid && o_in_ready;
        o_cmd.row_init  = (r_state == S_PREP) && i_status.do_row;
        o_cmd.cell_step = (r_state == S_ROW);
        o_cmd.finish    = (r_state == S_DONE);
        o_cmd.out_load  = (r_state == S_OUT);
        o_cmd.clear     = (r_state == S_OUT);
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_in_valid && o_in_ready) r_state <= S_PREP;
                S_PREP: r_state <= i_status.do_row ? S_ROW : S_DONE;
                S_ROW:  if (i_status.last_cell) r_state <= S_DONE;
                S_DONE: r_state <= i_status.is_last ? S_OUT : S_IDLE;
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hw/rtl/fwpm_datapath.sv -----
// distance row, one shared cell unit, offsets and result registers
module fwpm_datapath #(
    parameter int PHRASE_MAX = 16,
    parameter int MAX_TEXT   = 1024,
    parameter int OFF_W      = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  logic [7:0]        i_text_byte,
    input  logic              i_is_last,
    input  fwpm_pkg::t_cmd    i_cmd,
    output fwpm_pkg::t_status o_status,
    output logic              o_matched,
    output logic [3:0]        o_distance,
    output logic [OFF_W-1:0]  o_remainder_start,
    output logic [OFF_W-1:0]  o_remainder_end,
    output logic              o_text_too_long
);
    localparam int POS_W = $clog2(MAX_TEXT + 1);
    localparam int IDX_W = $clog2(PHRASE_MAX + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_TEXT);

    logic [63:0] r_chars_low, r_chars_high;
    logic [4:0]  r_len_cfg;
    logic [2:0]  r_max_edits;

    logic [4:0]       r_row [PHRASE_MAX+1];
    logic [4:0]       r_kept;
    logic [3:0]       r_best;
    logic [POS_W-1:0] r_pos, r_start, r_nonspace;
    logic             r_pending, r_too_long;
    logic [7:0]       r_c;
    logic             r_last, r_do_row, r_check;
    logic [4:0]       r_diag, r_left;
    logic [IDX_W-1:0] r_j;

    logic             r_matched;
    logic [3:0]       r_distance;
    logic [OFF_W-1:0] r_rem_start;
    logic [OFF_W-1:0] r_rem_end;
    logic             r_out_too_long;

    // effective phrase length
    logic [4:0] len;
    assign len = (r_len_cfg > 5'(PHRASE_MAX)) ? 5'(PHRASE_MAX) : r_len_cfg;

    // byte classification
    logic       is_alnum;
    logic [7:0] c_low;
    assign is_alnum = (i_text_byte >= 8'h30 && i_text_byte <= 8'h39) ||
                      (i_text_byte >= 8'h61 && i_text_byte <= 8'h7a) ||
                      (i_text_byte >= 8'h41 && i_text_byte <= 8'h5a);
    assign c_low = (i_text_byte >= 8'h41 && i_text_byte <= 8'h5a) ?
                   i_text_byte + 8'h20 : i_text_byte;

    // next kept count and row gating
    logic [4:0] kept_nx;
    logic [5:0] limit;
    logic [4:0] lo;
    assign kept_nx = (r_kept < fwpm_pkg::CELL_MAX) ? r_kept + 5'd1 : r_kept;
    assign limit   = {1'b0, len} + 6'(r_max_edits);
    assign lo      = (len > 5'(r_max_edits)) ? len - 5'(r_max_edits) : 5'd1;

    // position after this byte
    logic [POS_W-1:0] after;
    assign after = (r_pos >= MAX_POS) ? MAX_POS : r_pos + 1'b1;

    // shared cell unit
    logic [4:0] jm1;
    logic [7:0] pch;
    logic [4:0] up;
    logic [5:0] v0, v1, v2;
    logic [4:0] cell_val;
    assign jm1 = 5'(r_j) - 5'd1;
    assign pch = jm1[3] ? r_chars_high[{jm1[2:0], 3'b000} +: 8]
                        : r_chars_low[{jm1[2:0], 3'b000} +: 8];
    assign up  = r_row[r_j];
    assign v0  = {1'b0, r_diag} + 6'(r_c != pch);
    assign v1  = ({1'b0, up} + 6'd1 < v0) ? {1'b0, up} + 6'd1 : v0;
    assign v2  = ({1'b0, r_left} + 6'd1 < v1) ? {1'b0, r_left} + 6'd1 : v1;
    assign cell_val = (v2 > 6'd31) ? fwpm_pkg::CELL_MAX : v2[4:0];

    assign o_status.do_row    = r_do_row;
    assign o_status.last_cell = (5'(r_j) >= len);
    assign o_status.is_last   = r_last;

    // final candidate check
    logic [4:0] d_fin;
    assign d_fin = r_row[len[IDX_W-1:0]];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars_low  <= '0;
            r_chars_high <= '0;
            r_len_cfg    <= '0;
            r_max_edits  <= 3'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fwpm_pkg::REG_CHARS_LOW:  r_chars_low  <= i_cfg_data;
                fwpm_pkg::REG_CHARS_HIGH: r_chars_high <= i_cfg_data;
                fwpm_pkg::REG_LENGTH:     r_len_cfg    <= i_cfg_data[4:0];
                fwpm_pkg::REG_MAX_EDITS:  r_max_edits  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // transcript state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k <= PHRASE_MAX; k++) r_row[k] <= 5'(k);
            r_kept     <= '0;
            r_best     <= 4'(r_max_edits) + 4'd1;
            r_pos      <= '0;
            r_start    <= '0;
            r_nonspace <= '0;
            r_pending  <= 1'b0;
            r_too_long <= 1'b0;
            r_do_row   <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_c    <= c_low;
                r_last <= i_is_last;
                if (r_pos == '0) r_best <= 4'(r_max_edits) + 4'd1;
                if (r_pos >= MAX_POS) r_too_long <= 1'b1;
                r_pos <= after;
                if (r_pending) begin
                    if (fwpm_pkg::is_skip(i_text_byte)) r_start <= after;
                    else r_pending <= 1'b0;
                end
                if (i_text_byte != 8'h20) r_nonspace <= after;
                if (is_alnum) begin
                    r_kept   <= kept_nx;
                    r_do_row <= (len != 5'd0) && ({1'b0, kept_nx} <= limit);
                    r_check  <= (kept_nx >= lo);
                end else begin
                    r_do_row <= 1'b0;
                    r_check  <= 1'b0;
                end
            end
            if (i_cmd.row_init) begin
                r_diag   <= r_row[0];
                r_left   <= r_kept;
                r_row[0] <= r_kept;
                r_j      <= IDX_W'(1);
            end
            if (i_cmd.cell_step) begin
                r_row[r_j] <= cell_val;
                r_diag     <= up;
                r_left     <= cell_val;
                r_j        <= r_j + 1'b1;
            end
            if (i_cmd.finish && r_do_row && r_check) begin
                if (5'(r_best) > d_fin && d_fin <= 5'(r_max_edits)) begin
                    r_best    <= d_fin[3:0];
                    r_start   <= r_pos;
                    r_pending <= 1'b1;
                end
            end
        end
    end

    // result registers
    logic hit;
    logic [POS_W-1:0] end_off;
    assign hit     = r_best <= 4'(r_max_edits);
    assign end_off = (r_nonspace > r_start) ? r_nonspace : r_start;
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_matched      <= hit;
            r_distance     <= hit ? r_best : 4'(r_max_edits) + 4'd1;
            r_rem_start    <= hit ? OFF_W'(r_start) : '0;
            r_rem_end      <= hit ? OFF_W'(end_off) : '0;
            r_out_too_long <= r_too_long;
        end
    end

    assign o_matched         = r_matched;
    assign o_distance        = r_distance;
    assign o_remainder_start = r_rem_start;
    assign o_remainder_end   = r_rem_end;
    assign o_text_too_long   = r_out_too_long;
endmodule

// ----- hw/rtl/fuzzy_wake_phrase_prefix_match.sv -----
// top level of the fuzzy wake phrase prefix matcher
// Usage: transcript bytes enter on in_ch, one item per byte with is_last set on
// the final byte. Letters and digits advance one edit distance row against the
// configured phrase; on the last byte one result item leaves on out_ch with
// matched, distance, remainder offsets and the overlong flag. Other bytes
// produce no result.
// Timing: each accepted byte steps through the prep state, the row sweep when it
// updates the row, and the done state before the next byte is accepted; the row
// is swept one cell per cycle through a single shared cell unit. On a last byte
// the out state loads the result register and raises valid, and the next byte
// is accepted only after the result has been taken.
// Configuration: cfg_ch writes registers 0..3 (phrase low, phrase high,
// length, max edits); always ready, write only while idle.
// Reset: synchronous active low; clears configuration and transcript state.
// Stall: the result is held in the output register; the next byte is not
// accepted until the waiting result has been taken.
module fuzzy_wake_phrase_prefix_match #(
    parameter int PHRASE_MAX = 16,
    parameter int MAX_TEXT   = 1024
) (
    input logic        i_clk,
    input logic        i_rst_n,
    fwpm_in_if.sink    in_ch,
    fwpm_out_if.source out_ch,
    fwpm_cfg_if.sink   cfg_ch
);
    fwpm_pkg::t_cmd    cmd;
    fwpm_pkg::t_status status;

    assign cfg_ch.ready = 1'b1;

    fwpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    fwpm_datapath #(.PHRASE_MAX(PHRASE_MAX), .MAX_TEXT(MAX_TEXT), .OFF_W(11)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_ch.valid),
        .i_cfg_index       (cfg_ch.index),
        .i_cfg_data        (cfg_ch.data),
        .i_text_byte       (in_ch.text_byte),
        .i_is_last         (in_ch.is_last),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_matched         (out_ch.matched),
        .o_distance        (out_ch.distance),
        .o_remainder_start (out_ch.remainder_start),
        .o_remainder_end   (out_ch.remainder_end),
        .o_text_too_long   (out_ch.text_too_long)
    );

    // no new item while a result waits
    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("item accepted over pending result");
    // a result only follows the load command
    a_valid_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_ch.valid) |-> $past(cmd.out_load)) else $error("result without load");
    // commands of the sweep never overlap acceptance
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.start, cmd.row_init, cmd.cell_step, cmd.finish, cmd.out_load}))
        else $error("overlapping commands");
    // matched result keeps distance within limit
    a_match_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.matched) |-> out_ch.distance <= 4'd7)
        else $error("matched with large distance");
endmodule

// ----- dv/fwpm_tb_pkg.sv -----
`timescale 1ns / 100ps
// scoreboard class holding the wake phrase predictor and expected result queue
package fwpm_tb_pkg;
    typedef struct packed {
        logic        matched;
        logic [3:0]  distance;
        logic [10:0] rem_start;
        logic [10:0] rem_end;
        logic        too_long;
    } t_match_result;

    class phrase_scoreboard;
        // configuration copy
        logic [63:0] chars_lo, chars_hi;
        int unsigned plen, edits;
        // transcript state
        int unsigned row[17];
        int unsigned kept, best, pos, start_pend, start_off, end_off, overlong;
        t_match_result pending_results[$];
        int unsigned   n_errors, n_checked, n_matched, n_overlong;

        function void clear_text();
            for (int j = 0; j <= 16; j++) row[j] = j;
            kept = 0; best = edits + 1; pos = 0; start_pend = 0;
            start_off = 0; end_off = 0; overlong = 0;
        endfunction

        function void reset_all();
            chars_lo = '0; chars_hi = '0; plen = 0; edits = 2;
            clear_text();
        endfunction

        function void write_reg(fwpm_pkg::t_reg_index idx, logic [63:0] v);
            case (idx)
                fwpm_pkg::REG_CHARS_LOW:  chars_lo = v;
                fwpm_pkg::REG_CHARS_HIGH: chars_hi = v;
                fwpm_pkg::REG_LENGTH:     plen = v[4:0];
                fwpm_pkg::REG_MAX_EDITS:  edits = v[2:0];
                default: ;
            endcase
        endfunction

        function int unsigned phrase_at(int unsigned j);
            return (j < 8) ? chars_lo[8*j +: 8] : chars_hi[8*(j-8) +: 8];
        endfunction

        // one levenshtein row sweep for a kept character
        function void sweep_row(int unsigned c, int unsigned len);
            int unsigned diag, left, up, v;
            diag = row[0];
            left = (kept > 31) ? 31 : kept;
            row[0] = left;
            for (int j = 1; j <= len; j++) begin
                up = row[j];
                v = diag + ((c != phrase_at(j-1)) ? 1 : 0);
                if (up + 1 < v) v = up + 1;
                if (left + 1 < v) v = left + 1;
                if (v > 31) v = 31;
                row[j] = v;
                diag = up;
                left = v;
            end
        endfunction

        // note an accepted byte, queue a result on the last byte
        function void note_byte(logic [7:0] b, logic last);
            int unsigned c, len, nxt, lo, d, e;
            t_match_result r;
            c = b;
            len = (plen > 16) ? 16 : plen;
            if (pos == 0) best = edits + 1;
            if (pos >= 1024) begin
                overlong = 1; nxt = 1024;
            end else nxt = pos + 1;
            pos = nxt;
            if (start_pend) begin
                if (fwpm_pkg::is_skip(b)) start_off = nxt;
                else start_pend = 0;
            end
            if (c != 32) end_off = nxt;
            if ((c >= 48 && c <= 57) || (c >= 97 && c <= 122) || (c >= 65 && c <= 90)) begin
                if (c >= 65 && c <= 90) c += 32;
                if (kept < 31) kept++;
                if (len > 0 && kept <= len + edits) begin
                    lo = (len > edits) ? len - edits : 1;
                    sweep_row(c, len);
                    if (kept >= lo) begin
                        d = row[len];
                        if (d < best && d <= edits) begin
                            best = d; start_off = nxt; start_pend = 1;
                        end
                    end
                end
            end
            if (!last) return;
            e = (end_off > start_off) ? end_off : start_off;
            r.matched = (best <= edits);
            r.distance = 4'(r.matched ? best : edits + 1);
            r.rem_start = 11'(r.matched ? start_off : 0);
            r.rem_end = 11'(r.matched ? e : 0);
            r.too_long = 1'(overlong);
            pending_results = {pending_results, r};
            clear_text();
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            n_errors++;
        endtask

        task check_result(t_match_result got);
            t_match_result w;
            if (pending_results.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            w = pending_results.pop_front();
            n_checked++;
            if (w.matched) n_matched++;
            if (w.too_long) n_overlong++;
            if (got.matched !== w.matched)
                report($sformatf("matched got %0d want %0d", got.matched, w.matched));
            if (got.distance !== w.distance)
                report($sformatf("distance got %0d want %0d", got.distance, w.distance));
            if (got.rem_start !== w.rem_start)
                report($sformatf("start got %0d want %0d", got.rem_start, w.rem_start));
            if (got.rem_end !== w.rem_end)
                report($sformatf("end got %0d want %0d", got.rem_end, w.rem_end));
            if (got.too_long !== w.too_long)
                report($sformatf("too_long got %0d want %0d", got.too_long, w.too_long));
        endtask
    endclass
endpackage

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// top testbench for the fuzzy wake phrase prefix matcher
module tb_top;
    localparam int LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int unsigned cycles = 0;
    int unsigned n_bytes = 0;
    bit no_idle = 1'b0;
    fwpm_tb_pkg::phrase_scoreboard sb = new();

    fwpm_in_if  in_ch();
    fwpm_out_if out_ch();
    fwpm_cfg_if cfg_ch();

    fuzzy_wake_phrase_prefix_match dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0; in_ch.text_byte = '0; in_ch.is_last = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.index = fwpm_pkg::REG_CHARS_LOW; cfg_ch.data = '0;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout");
            $display("tb_top: errors");
            $finish;
        end
    end

    // result sink with random stalls
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result({out_ch.matched, out_ch.distance, out_ch.remainder_start,
                             out_ch.remainder_end, out_ch.text_too_long});
        out_ch.ready <= no_idle || ($urandom_range(99) >= 15);
    end

    // valid stays high between back to back items and drops only while idling
    task automatic send_byte(logic [7:0] b, logic last);
        cfg_ch.valid <= 1'b0;
        while (!no_idle && $urandom_range(99) < 15) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1; in_ch.text_byte <= b; in_ch.is_last <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_byte(b, last);
        n_bytes++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    // cfg valid is dropped by the next byte sent
    task automatic write_cfg(fwpm_pkg::t_reg_index idx, logic [63:0] v);
        cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, v);
    endtask

    // wait for all results, then for trailing ignored bytes to finish
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_phrase(string p, int unsigned ed);
        logic [127:0] packed_p;
        packed_p = '0;
        for (int i = 0; i < p.len() && i < 16; i++) packed_p[8*i +: 8] = p[i];
        write_cfg(fwpm_pkg::REG_CHARS_LOW, packed_p[63:0]);
        write_cfg(fwpm_pkg::REG_CHARS_HIGH, packed_p[127:64]);
        write_cfg(fwpm_pkg::REG_LENGTH, p.len());
        write_cfg(fwpm_pkg::REG_MAX_EDITS, ed);
    endtask

    function automatic logic [7:0] rand_char();
        string skip_chars;
        string upper_chars;
        string plain_chars;
        int unsigned k;
        skip_chars = " ,.!?;:-";
        upper_chars = "ABCXYZ09";
        plain_chars = "abcdefghijklmnopqrstuvwxyz0123456789";
        k = $urandom_range(99);
        if (k < 8) return skip_chars[$urandom_range(7)];
        if (k < 14) return 8'($urandom_range(255));
        if (k < 18) return upper_chars[$urandom_range(7)];
        return plain_chars[$urandom_range(35)];
    endfunction

    // transcript: phrase with random edits, separators, then a tail
    task automatic send_phrase_text(string p);
        string t;
        string punct;
        int unsigned k, tail;
        t = "";
        punct = " ,.!-";
        for (int i = 0; i < $urandom_range(2); i++) t = {t, " "};
        for (int i = 0; i < p.len(); i++) begin
            k = $urandom_range(99);
            if (k < 6) continue;
            if (k < 12) t = {t, string'(rand_char())};
            else if (k < 16) t = {t, string'(p[i]), string'(rand_char())};
            else if (k < 24) t = {t, string'(p[i] - 8'd32 * (p[i] >= "a"))};
            else t = {t, string'(p[i])};
            if ($urandom_range(9) == 0) t = {t, " "};
        end
        for (int i = 0; i < $urandom_range(3); i++)
            t = {t, string'(punct[$urandom_range(4)])};
        tail = $urandom_range(12);
        for (int i = 0; i < tail; i++) t = {t, string'(rand_char())};
        for (int i = 0; i < $urandom_range(2); i++) t = {t, " "};
        send_text(t);
    endtask

    initial begin
        string phrases[6];
        string p;
        int unsigned nraw, ph_start;
        phrases = '{"heychan", "ok", "computerwakeup12", "a", "hellorobotfriend", "x9z"};
        sb.reset_all();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config (length zero never matches)
        send_text("hey chan");
        drain();
        set_phrase("heychan", 2);
        send_text("hey chan, turn on the light  ");
        send_text("Hey-Chan!!  ");
        send_text("hey");
        send_text("x");
        send_byte(8'hff, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h7f, 1'b1);
        drain();
        set_phrase("computerwakeup12", 7);
        send_text("computer wake up 12 ... go   ");
        send_text("cmptr wkup");
        drain();
        set_phrase("a", 0);
        send_text("a?b ");
        send_text("b");
        drain();
        write_cfg(fwpm_pkg::REG_LENGTH, 31);   // above the phrase maximum
        write_cfg(fwpm_pkg::REG_CHARS_HIGH, 64'hffff_ffff_ffff_ffff);
        send_text("a");
        drain();
        // overlong transcript
        set_phrase("ok", 1);
        for (int i = 0; i < 1030; i++)
            send_byte((i == 0) ? "o" : (i == 1) ? "k" : " ", i == 1029);
        drain();

        // random phases, one with no idling
        for (int ph = 0; ph < 12; ph++) begin
            no_idle = (ph == 5);
            p = phrases[$urandom_range(5)];
            set_phrase(p, (ph % 4 == 0) ? 0 : (ph % 4 == 1) ? 7 : $urandom_range(7));
            if (ph == 7) write_cfg(fwpm_pkg::REG_CHARS_LOW, {$urandom, $urandom});
            ph_start = n_bytes;
            while (n_bytes - ph_start < 60) begin
                if ($urandom_range(9) < 8) send_phrase_text(p);
                else begin
                    nraw = $urandom_range(1, 20);
                    for (int i = 0; i < nraw; i++)
                        send_byte(8'($urandom_range(255)), i == nraw - 1);
                end
            end
            drain();
        end
        no_idle = 1'b0;
        drain();
        repeat (40) @(posedge i_clk);

        $display("covered %0d bytes, %0d results (%0d matched, %0d overlong)",
                 n_bytes, sb.n_checked, sb.n_matched, sb.n_overlong);
        if (sb.n_errors == 0 && sb.pending_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
